>>> sv/dahf_pkg.sv
`timescale 1ns / 1ps
package dahf_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int CONC_WIDTH  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  // item kinds
  localparam logic [1:0] KIND_GLU  = 2'd0;
  localparam logic [1:0] KIND_DHPG = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // register indexes
  localparam logic [2:0] REG_GLU_K  = 3'd0;
  localparam logic [2:0] REG_GLU_V  = 3'd1;
  localparam logic [2:0] REG_GLU_N  = 3'd2;
  localparam logic [2:0] REG_DHPG_K = 3'd3;
  localparam logic [2:0] REG_DHPG_V = 3'd4;
  localparam logic [2:0] REG_DHPG_N = 3'd5;

  typedef struct packed {
    logic [1:0]            kind;
    logic [CONC_WIDTH-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [30:0] flux_glu;
    logic [30:0] flux_dhpg;
    logic [30:0] flux_total;
  } result_t;

  typedef struct packed {
    logic [30:0] glu_sum;
    logic [30:0] dhpg_sum;
  } job_t;

  typedef struct packed {
    logic [30:0] glu_k;
    logic [30:0] glu_v;
    logic [15:0] glu_n;
    logic [30:0] dhpg_k;
    logic [30:0] dhpg_v;
    logic [15:0] dhpg_n;
  } cfg_t;

  typedef logic [15:0][30:0] exp_tab_t;

  // c_0 = 2^29, c_i = isqrt(c_(i-1) * 2^30); entry i-1 holds c_i (2^-(2^-i) in Q0.30)
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    c = 64'd1 << 29;
    for (int i = 0; i < 16; i++) begin
      v   = c << 30;
      res = '0;
      bt  = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (bt > v) bt = bt >> 2;
      end
      for (int j = 0; j < 32; j++) begin
        if (bt != 0) begin
          if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
          end else begin
            res = res >> 1;
          end
          bt = bt >> 2;
        end
      end
      c      = res;
      tab[i] = c[30:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> sv/dahf_queue.sv
`timescale 1ns / 1ps
module dahf_queue #(
  parameter int W     = 62,
  parameter int DEPTH = dahf_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end
endmodule

>>> sv/dahf_front.sv
`timescale 1ns / 1ps
module dahf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dahf_pkg::item_t item,
  output logic            job_push,
  output dahf_pkg::job_t  job
);
  import dahf_pkg::*;

  localparam int XW = (CONC_WIDTH > 32) ? CONC_WIDTH : 32;

  logic [30:0] glu_sum;
  logic [30:0] dhpg_sum;
  logic [30:0] val;
  logic [XW-1:0] ext;
  logic [31:0] glu_add;
  logic [31:0] dhpg_add;

  // negative clamps to zero, oversize to full scale
  always_comb begin
    ext = XW'(item.sample);
    if (item.sample[CONC_WIDTH-1])   val = '0;
    else if (ext > XW'(MAX31))       val = MAX31;
    else                             val = ext[30:0];
  end

  assign glu_add  = {1'b0, glu_sum} + {1'b0, val};
  assign dhpg_add = {1'b0, dhpg_sum} + {1'b0, val};

  assign job_push     = accept && (item.kind == KIND_EVAL);
  assign job.glu_sum  = glu_sum;
  assign job.dhpg_sum = dhpg_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      glu_sum  <= '0;
      dhpg_sum <= '0;
    end else if (accept) begin
      unique case (item.kind)
        KIND_GLU:  glu_sum  <= glu_add[31] ? MAX31 : glu_add[30:0];
        KIND_DHPG: dhpg_sum <= dhpg_add[31] ? MAX31 : dhpg_add[30:0];
        KIND_EVAL: begin
          glu_sum  <= '0;
          dhpg_sum <= '0;
        end
        KIND_NONE: ;
        default: ;
      endcase
    end
  end
endmodule

>>> sv/dahf_back.sv
`timescale 1ns / 1ps
module dahf_back (
  input  logic              clk,
  input  logic              rst,
  input  dahf_pkg::cfg_t    cfg,
  input  logic              job_empty,
  input  dahf_pkg::job_t    job,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output dahf_pkg::result_t res
);
  import dahf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_LOGX  = 4'd2;
  localparam logic [3:0] S_LOGK  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_EXP   = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_NUM   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [5:0] DIV_LAST = 6'd60;

  logic [3:0]  state;
  logic        sel;
  logic [5:0]  cnt;
  job_t        job_r;
  logic [30:0] m;
  logic [4:0]  p;
  logic [15:0] frac;
  logic signed [23:0] logx;
  logic signed [23:0] d;
  logic        neg;
  logic [12:0] ai;
  logic [15:0] fr;
  logic [30:0] t;
  logic [60:0] num;
  logic [31:0] den;
  logic [31:0] rem;
  logic [30:0] flux_g;
  logic [30:0] flux_d;

  logic [30:0] x;
  logic [30:0] k;
  logic [30:0] v;
  logic [15:0] n;
  logic [4:0]  px;
  logic [4:0]  pk;
  logic [61:0] sq;
  logic [31:0] sqs;
  logic [30:0] m_next;
  logic [15:0] frac_next;
  logic signed [23:0] log_now;
  logic signed [40:0] prod;
  logic signed [28:0] e;
  logic [28:0] ea;
  logic [60:0] tc;
  logic [32:0] r2;
  logic [31:0] tot;

  always_comb begin
    x = sel ? job_r.dhpg_sum : job_r.glu_sum;
    k = sel ? cfg.dhpg_k : cfg.glu_k;
    v = sel ? cfg.dhpg_v : cfg.glu_v;
    n = sel ? cfg.dhpg_n : cfg.glu_n;
  end

  // leading one positions
  always_comb begin
    px = '0;
    pk = '0;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) px = 5'(i);
      if (k[i]) pk = 5'(i);
    end
  end

  // one squaring step of the log2 fraction
  always_comb begin
    sq        = 62'(m) * 62'(m);
    sqs       = sq[61:30];
    frac_next = {frac[14:0], sqs[31]};
    m_next    = sqs[31] ? sqs[31:1] : sqs[30:0];
    log_now   = {8'(p) - 8'(FRAC_BITS), frac_next};
  end

  always_comb begin
    prod = d * $signed({1'b0, n});
    e    = prod[40:12];
    ea   = e[28] ? 29'(-e) : 29'(e);
    tc   = 61'(t) * 61'(EXP_TAB[cnt[3:0]]);
    r2   = {rem, num[60]};
    tot  = {1'b0, flux_g} + {1'b0, flux_d};
  end

  assign job_pop         = (state == S_IDLE) && !job_empty;
  assign res_push        = (state == S_OUT);
  assign res.flux_glu    = flux_g;
  assign res.flux_dhpg   = flux_d;
  assign res.flux_total  = tot[31] ? MAX31 : tot[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (!job_empty) begin
          job_r <= job;
          sel   <= 1'b0;
          state <= S_START;
        end
        S_START: begin
          cnt  <= '0;
          frac <= '0;
          if (x == '0) begin
            num   <= '0;
            state <= S_NEXT;
          end else if (k == '0) begin
            num   <= 61'(v);
            state <= S_NEXT;
          end else begin
            m     <= x << (5'd30 - px);
            p     <= px;
            state <= S_LOGX;
          end
        end
        S_LOGX: begin
          cnt  <= cnt + 1'b1;
          m    <= m_next;
          frac <= frac_next;
          if (cnt[3:0] == 4'd15) begin
            logx  <= log_now;
            m     <= k << (5'd30 - pk);
            p     <= pk;
            frac  <= '0;
            cnt   <= '0;
            state <= S_LOGK;
          end
        end
        S_LOGK: begin
          cnt  <= cnt + 1'b1;
          m    <= m_next;
          frac <= frac_next;
          if (cnt[3:0] == 4'd15) begin
            d     <= logx - log_now;
            cnt   <= '0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          neg   <= e[28];
          ai    <= ea[28:16];
          fr    <= ea[15:0];
          t     <= 31'd1 << 30;
          cnt   <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          cnt <= cnt + 1'b1;
          if (fr[4'd15 - cnt[3:0]]) t <= tc[60:30];
          if (cnt[3:0] == 4'd15) state <= S_SHIFT;
        end
        S_SHIFT: begin
          t     <= (ai >= 13'd31) ? '0 : (t >> ai[4:0]);
          state <= S_NUM;
        end
        S_NUM: begin
          num   <= neg ? 61'(v) * 61'(t) : {v, 30'd0};
          den   <= 32'(31'd1 << 30) + 32'(t);
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (r2 >= {1'b0, den}) begin
            rem <= 32'(r2 - {1'b0, den});
            num <= {num[59:0], 1'b1};
          end else begin
            rem <= r2[31:0];
            num <= {num[59:0], 1'b0};
          end
          if (cnt == DIV_LAST) state <= S_NEXT;
        end
        S_NEXT: begin
          if (!sel) begin
            flux_g <= num[30:0];
            sel    <= 1'b1;
            state  <= S_START;
          end else begin
            flux_d <= num[30:0];
            state  <= S_OUT;
          end
        end
        S_OUT: if (!res_full) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/dual_agonist_hill_flux_top.sv
`timescale 1ns / 1ps
// Two-agonist Hill flux. Glutamate and DHPG samples (signed Q8.24, negatives
// count as zero) are summed into two saturating 31-bit sums at one beat per
// cycle. An evaluate beat snapshots both sums, clears them, and queues a job;
// the back end then forms v*r/(1+r), r = 2^(n*(log2 x - log2 k)), for each
// agonist and returns one result beat with both fluxes and their saturated
// total. Sample beats give no result, kind 3 is ignored. Per agonist, the
// back end runs two 16-step log2 squarings, a 16-step exp2 and a 61-step
// restoring divide. Samples keep flowing meanwhile; push stalls only when
// two evaluates already wait. Configure only while idle.
module dual_agonist_hill_flux_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  dahf_pkg::item_t     item,
  output logic                empty,
  input  logic                pop,
  output dahf_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import dahf_pkg::*;

  cfg_t    cfg;
  job_t    job_in;
  job_t    job_out;
  logic    job_push;
  logic    job_pop;
  logic    job_empty;
  logic    res_push;
  logic    res_full;
  result_t res;
  logic    accept;

  // register file: reset values k = 1.0, v = 0, n = 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glu_k  <= 31'd16777216;
      cfg.glu_v  <= '0;
      cfg.glu_n  <= 16'd4096;
      cfg.dhpg_k <= 31'd16777216;
      cfg.dhpg_v <= '0;
      cfg.dhpg_n <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLU_K:  cfg.glu_k  <= cfg_data;
        REG_GLU_V:  cfg.glu_v  <= cfg_data;
        REG_GLU_N:  cfg.glu_n  <= cfg_data[15:0];
        REG_DHPG_K: cfg.dhpg_k <= cfg_data;
        REG_DHPG_V: cfg.dhpg_v <= cfg_data;
        REG_DHPG_N: cfg.dhpg_n <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  // front: accumulate and issue evaluate jobs
  dahf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  // job queue between front and back
  dahf_queue #(.W($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  // back: log2 / exp2 / divide sequencer
  dahf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  dahf_queue #(.W($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );
endmodule

>>> bench/dual_agonist_hill_flux_check.sv
`timescale 1ns / 1ps
module dual_agonist_hill_flux_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  dahf_pkg::item_t   item,
  input  logic              empty,
  input  logic              pop,
  input  dahf_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data,
  output int                fails,
  output int                pending,
  output int                checked
);
  import dahf_pkg::*;

  logic [30:0] glu_k, glu_v, dhpg_k, dhpg_v;
  logic [15:0] glu_n, dhpg_n;
  logic [30:0] glu_acc, dhpg_acc;
  logic [63:0] root_tab [1:16];
  result_t     flux_due [$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      c = floor_sqrt(c << 30);
      root_tab[i] = c;
    end
  end

  // log2 in signed Q.16
  function automatic longint conc_log2(logic [30:0] x);
    int          p;
    logic [63:0] m;
    longint      frac;
    p = 30;
    while (p > 0 && !x[p]) p--;
    m = 64'(x) << (30 - p);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(p - FRAC_BITS) * 65536 + frac;
  endfunction

  // 2^-a, a in Q.16, result Q0.30
  function automatic logic [63:0] pow2_neg(logic [63:0] a);
    logic [63:0] t;
    logic [63:0] ai;
    t = 64'd1 << 30;
    ai = a >> 16;
    for (int i = 1; i <= 16; i++)
      if (a[16-i]) t = (t * root_tab[i]) >> 30;
    if (ai >= 31) return 0;
    return t >> ai;
  endfunction

  function automatic logic [30:0] hill_flux(logic [30:0] x, logic [30:0] k,
                                            logic [30:0] v, logic [15:0] n);
    longint      d, e;
    logic [63:0] t, q;
    if (x == 0) return 0;
    if (k == 0) return v;
    d = conc_log2(x) - conc_log2(k);
    e = (d * longint'({48'd0, n})) >>> 12;
    if (e >= 0) begin
      t = pow2_neg(64'(e));
      q = (64'(v) << 30) / ((64'd1 << 30) + t);
    end else begin
      t = pow2_neg(64'(-e));
      q = (64'(v) * t) / ((64'd1 << 30) + t);
    end
    return q[30:0];
  endfunction

  function automatic logic [30:0] sat_add(logic [30:0] a, logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31] ? MAX31 : s[30:0];
  endfunction

  assign pending = flux_due.size();

  always @(posedge clk) begin
    logic [30:0] conc;
    result_t     want;
    if (rst) begin
      glu_k <= 31'd16777216; glu_v <= '0; glu_n <= 16'd4096;
      dhpg_k <= 31'd16777216; dhpg_v <= '0; dhpg_n <= 16'd4096;
      glu_acc <= '0; dhpg_acc <= '0;
      fails <= 0; checked <= 0;
      flux_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GLU_K:  glu_k  <= cfg_data;
          REG_GLU_V:  glu_v  <= cfg_data;
          REG_GLU_N:  glu_n  <= cfg_data[15:0];
          REG_DHPG_K: dhpg_k <= cfg_data;
          REG_DHPG_V: dhpg_v <= cfg_data;
          REG_DHPG_N: dhpg_n <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        conc = item.sample[CONC_WIDTH-1] ? 31'd0 : item.sample[30:0];
        case (item.kind)
          KIND_GLU:  glu_acc  <= sat_add(glu_acc, conc);
          KIND_DHPG: dhpg_acc <= sat_add(dhpg_acc, conc);
          KIND_EVAL: begin
            want.flux_glu   = hill_flux(glu_acc, glu_k, glu_v, glu_n);
            want.flux_dhpg  = hill_flux(dhpg_acc, dhpg_k, dhpg_v, dhpg_n);
            want.flux_total = sat_add(want.flux_glu, want.flux_dhpg);
            flux_due.push_back(want);
            glu_acc  <= '0;
            dhpg_acc <= '0;
          end
          default: ;
        endcase
      end
      if (pop && !empty) begin
        checked <= checked + 1;
        if (flux_due.size() == 0) begin
          if (fails < 10) $display("unexpected result beat %h", result);
          fails <= fails + 1;
        end else begin
          want = flux_due.pop_front();
          if (result !== want) begin
            if (fails < 10)
              $display("flux mismatch: glu %h/%h dhpg %h/%h total %h/%h (exp/got)",
                       want.flux_glu, result.flux_glu, want.flux_dhpg,
                       result.flux_dhpg, want.flux_total, result.flux_total);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/dual_agonist_hill_flux_top_test.sv
`timescale 1ns / 1ps
module dual_agonist_hill_flux_top_test;
  import dahf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk, rst, push, full, empty, pop, cfg_we;
  item_t       item;
  result_t     result;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  int          fails, pending, checked;
  int          idle_pct;
  int          cycles = 0;
  int          beats_sent, evals_sent, settings_used;

  dual_agonist_hill_flux_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dual_agonist_hill_flux_check chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .checked(checked)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dual_agonist_hill_flux_top: mismatch");
      $finish;
    end
  end

  // result side: random back-pressure, none while idle_pct is zero
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // one input beat; push is left high after acceptance so back-to-back beats
  // never see a low/high pair in one step
  task automatic send(logic [1:0] kind, logic [CONC_WIDTH-1:0] conc);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{kind: kind, sample: conc};
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    if (kind == KIND_EVAL) evals_sent++;
  endtask

  // drain all outstanding results, then let the back end settle
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // all six registers plus one write to an unmapped index
  task automatic load_regs(logic [30:0] gk, logic [30:0] gv, logic [15:0] gn,
                           logic [30:0] dk, logic [30:0] dv, logic [15:0] dn);
    logic [30:0] vals [6];
    vals = '{gk, gv, 31'(gn), dk, dv, 31'(dn)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i] | ((i == 2 || i == 5) ? {15'($urandom), 16'd0} : 31'd0);
      @(posedge clk);
    end
    cfg_index <= $urandom_range(0, 1) ? 3'd6 : 3'd7;
    cfg_data <= 31'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] rand_conc();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return 32'h8000_0000 | $urandom;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0;
      default: return $urandom_range(0, 32'h0400_0000) >> $urandom_range(0, 22);
    endcase
  endfunction

  function automatic logic [30:0] rand_k();
    case ($urandom_range(0, 5))
      0:       return 31'd1;
      1:       return MAX31;
      2:       return 31'($urandom);
      default: return 31'($urandom_range(1 << 20, 1 << 27));
    endcase
  endfunction

  function automatic logic [30:0] rand_v();
    case ($urandom_range(0, 4))
      0:       return 31'd0;
      1:       return MAX31;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_n();
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1024, 16384));
    endcase
  endfunction

  initial begin
    int burst;
    rst = 1'b1; push = 1'b0; item = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    idle_pct = 33;
    beats_sent = 0; evals_sent = 0; settings_used = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty sums, then v = 0 gives zero flux
    send(KIND_EVAL, 32'h0);
    send(KIND_GLU, 32'h0100_0000);
    send(KIND_DHPG, 32'h0200_0000);
    send(KIND_EVAL, 32'h0);
    settle();

    // full-scale v, unit k and n: extremes of the sample field, saturating sum
    load_regs(31'd16777216, MAX31, 16'd4096, 31'd16777216, MAX31, 16'd4096);
    send(KIND_GLU, 32'h7FFF_FFFF);
    send(KIND_GLU, 32'h8000_0000);          // most negative, clamps to zero
    send(KIND_GLU, 32'hFFFF_FFFF);
    send(KIND_DHPG, 32'h7FFF_FFFF);
    send(KIND_DHPG, 32'h7FFF_FFFF);          // sum pins at the top
    send(KIND_NONE, 32'h1234_5678);          // unused kind, no effect
    send(KIND_EVAL, 32'hFFFF_FFFF);
    send(KIND_GLU, 32'h0000_0001);           // smallest sum
    send(KIND_DHPG, 32'h0100_0000);          // sum equals k
    send(KIND_EVAL, 32'h0);
    settle();

    // zero k: flux is v for any nonzero sum; zero n: flux is v/2
    load_regs(31'd0, 31'h5555_5555, 16'd4096, 31'h0080_0000, MAX31, 16'd0);
    send(KIND_GLU, 32'h0000_0010);
    send(KIND_DHPG, 32'h0300_0000);
    send(KIND_EVAL, 32'h0);
    send(KIND_DHPG, 32'h0000_0001);
    send(KIND_EVAL, 32'h0);
    settle();

    // extremes of k and n
    load_regs(31'd1, MAX31, 16'hFFFF, MAX31, 31'd1, 16'd1);
    send(KIND_GLU, 32'h0000_0002);
    send(KIND_DHPG, 32'h0000_0001);
    send(KIND_EVAL, 32'h0);
    send(KIND_GLU, 32'h7FFF_FFFF);
    send(KIND_EVAL, 32'h0);
    settle();

    // random phases, each under fresh register values; one runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph == 3) ? 0 : 33;
      load_regs(rand_k(), rand_v(), rand_n(), rand_k(), rand_v(), rand_n());
      for (int n = 0; n < 125; ) begin
        if ($urandom_range(0, 9) < 8) begin
          // well-formed: a burst of samples closed by an evaluate
          burst = $urandom_range(0, 6);
          for (int b = 0; b < burst; b++) begin
            send($urandom_range(0, 1) ? KIND_GLU : KIND_DHPG, rand_conc());
            n++;
          end
          send(KIND_EVAL, $urandom);
          n++;
        end else begin
          send(2'($urandom), $urandom);      // noise, unused kind included
          n++;
        end
      end
      settle();
    end

    repeat (300) @(posedge clk);
    $display("covered %0d input beats, %0d evaluates, %0d register settings",
             beats_sent, evals_sent, settings_used);
    $display("%0d result beats compared, %0d failures", checked, fails);
    if (fails == 0 && pending == 0) begin
      $display("dual_agonist_hill_flux_top: match");
    end else begin
      $display("dual_agonist_hill_flux_top: mismatch");
    end
    $finish;
  end
endmodule
